// ----- design/mbg_pkg.sv -----
package mbg_pkg;

   // Request mode codes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_STEP  = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Neighbour probe order: up, down, left, right
   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   // Remainder of a 16-bit value by three: fold base-4 digits (4 == 1 mod 3)
   function automatic logic [1:0] mod3(input logic [15:0] value);
      logic [4:0] digit_sum;
      logic [2:0] fold;
      logic [2:0] rem;
      digit_sum = '0;
      for (int i = 0; i < 8; i++) begin
         digit_sum = digit_sum + {3'b000, value[2*i +: 2]};
      end
      fold = {1'b0, digit_sum[1:0]} + {1'b0, digit_sum[3:2]} + {2'b00, digit_sum[4]};
      if (fold >= 3'd6) begin
         rem = fold - 3'd6;
      end else if (fold >= 3'd3) begin
         rem = fold - 3'd3;
      end else begin
         rem = fold;
      end
      return rem[1:0];
   endfunction

   // Direction of the k-th set bit in the candidate mask
   function automatic dir_type pick_dir(input logic [3:0] avail, input logic [1:0] k);
      logic [2:0] seen;
      logic       found;
      dir_type    dir;
      seen  = '0;
      found = 1'b0;
      dir   = DIR_UP;
      for (int d = 0; d < 4; d++) begin
         if (avail[d] && !found) begin
            if (seen == {1'b0, k}) begin
               dir   = dir_type'(2'(d));
               found = 1'b1;
            end
            seen = seen + 3'd1;
         end
      end
      return dir;
   endfunction

endpackage

// ----- design/mbg_ram.sv -----
module mbg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/maze_backtracker_generator.sv -----
// Start: sweeps the whole map to walls, one map word cleared per cycle, opening the start
//   cell on the way and pushing it as the only stack entry.
// Throughput: one item at a time; a step probes the neighbours in turn on the single
//   map read port, and a carve makes two map writes on its single write port.
// Reset: synchronous, active high; stack empty, map reads as wall until the first start.
module maze_backtracker_generator #(
   parameter int GRID_ROWS   = 32,
   parameter int GRID_COLS   = 32,
   parameter int STACK_DEPTH = 289
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_rand_value,
   input  logic [4:0]  req_read_row,
   input  logic [4:0]  req_read_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_passage,
   output logic        rsp_carved,
   output logic [4:0]  rsp_wall_row,
   output logic [4:0]  rsp_wall_col,
   output logic [4:0]  rsp_cell_row,
   output logic [4:0]  rsp_cell_col,
   output logic        rsp_done_res
);

   // Map word address is {row, col}; reads of padding words beyond the grid are masked.
   localparam int RW        = $clog2(GRID_ROWS);
   localparam int CW        = $clog2(GRID_COLS);
   localparam int MA        = RW + CW;
   localparam int MAP_DEPTH = 1 << MA;
   localparam int SA        = $clog2(STACK_DEPTH);
   localparam int LW        = $clog2(STACK_DEPTH + 1);
   localparam int ROW_MAX   = GRID_ROWS - 2;
   localparam int COL_MAX   = GRID_COLS - 2;

   localparam logic [MA-1:0] START_CELL = {RW'(1), CW'(1)};

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_TOP,
      S_PROBE,
      S_PICK,
      S_WALL,
      S_CELL,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [LW-1:0]  level_ff, level_in;
   logic           live_ff, live_in;         // map holds a maze since a start
   logic [MA-1:0]  clr_ff, clr_in;
   logic [15:0]    rand_ff, rand_in;
   logic           read_ok_ff, read_ok_in;
   logic           passage_ff, passage_in;
   logic           carved_ff, carved_in;
   logic [MA-1:0]  top_ff, top_in;
   logic [2:0]     probe_ff, probe_in;
   logic [3:0]     avail_ff, avail_in;
   mbg_pkg::dir_type dir_ff, dir_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_is_passage_ff, rsp_is_passage_in;
   logic           rsp_carved_ff, rsp_carved_in;
   logic [4:0]     rsp_wall_row_ff, rsp_wall_row_in;
   logic [4:0]     rsp_wall_col_ff, rsp_wall_col_in;
   logic [4:0]     rsp_cell_row_ff, rsp_cell_row_in;
   logic [4:0]     rsp_cell_col_ff, rsp_cell_col_in;
   logic           rsp_done_res_ff, rsp_done_res_in;

   // Memory ports
   logic           map_we, map_re, map_wd, map_rd;
   logic [MA-1:0]  map_wa, map_ra;
   logic           stk_we, stk_re;
   logic [SA-1:0]  stk_wa, stk_ra;
   logic [MA-1:0]  stk_wd, stk_rd;

   // Neighbour geometry around the stack top
   logic [RW-1:0]  top_row;
   logic [CW-1:0]  top_col;
   logic [MA-1:0]  nbr_addr  [4];
   logic [MA-1:0]  wall_addr [4];
   logic [3:0]     in_bounds;
   logic [1:0]     prev_dir;
   logic [2:0]     cand_count;
   logic [1:0]     cand_pick;
   logic           read_in_range;

   mbg_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_en   (map_re),
      .rd_addr (map_ra),
      .rd_data (map_rd)
   );

   mbg_ram #(
      .WIDTH (MA),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_en   (stk_re),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   assign top_row = top_ff[MA-1:CW];
   assign top_col = top_ff[CW-1:0];

   // Targets two cells away and the wall cell between, per direction.
   // Bounds keep the neighbour strictly inside the border ring.
   always_comb begin
      nbr_addr[mbg_pkg::DIR_UP]     = {top_row - RW'(2), top_col};
      nbr_addr[mbg_pkg::DIR_DOWN]   = {top_row + RW'(2), top_col};
      nbr_addr[mbg_pkg::DIR_LEFT]   = {top_row, top_col - CW'(2)};
      nbr_addr[mbg_pkg::DIR_RIGHT]  = {top_row, top_col + CW'(2)};
      wall_addr[mbg_pkg::DIR_UP]    = {top_row - RW'(1), top_col};
      wall_addr[mbg_pkg::DIR_DOWN]  = {top_row + RW'(1), top_col};
      wall_addr[mbg_pkg::DIR_LEFT]  = {top_row, top_col - CW'(1)};
      wall_addr[mbg_pkg::DIR_RIGHT] = {top_row, top_col + CW'(1)};
      in_bounds[mbg_pkg::DIR_UP]    = ({1'b0, top_row} >= (RW+1)'(3));
      in_bounds[mbg_pkg::DIR_DOWN]  = ({1'b0, top_row} + (RW+1)'(2) <= (RW+1)'(ROW_MAX));
      in_bounds[mbg_pkg::DIR_LEFT]  = ({1'b0, top_col} >= (CW+1)'(3));
      in_bounds[mbg_pkg::DIR_RIGHT] = ({1'b0, top_col} + (CW+1)'(2) <= (CW+1)'(COL_MAX));
   end

   assign prev_dir      = 2'(probe_ff - 3'd1);
   assign cand_count    = 3'($countones(avail_ff));
   assign read_in_range = (int'(req_read_row) < GRID_ROWS) && (int'(req_read_col) < GRID_COLS);

   // Entry index = rand mod candidate count (count is 1 to 4)
   always_comb begin
      case (cand_count)
         3'd2:    cand_pick = {1'b0, rand_ff[0]};
         3'd3:    cand_pick = mbg_pkg::mod3(rand_ff);
         3'd4:    cand_pick = rand_ff[1:0];
         default: cand_pick = 2'd0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      level_in   = level_ff;
      live_in    = live_ff;
      clr_in     = clr_ff;
      rand_in    = rand_ff;
      read_ok_in = read_ok_ff;
      passage_in = passage_ff;
      carved_in  = carved_ff;
      top_in     = top_ff;
      probe_in   = probe_ff;
      avail_in   = avail_ff;
      dir_in     = dir_ff;

      // Drop the held result once its transfer completes
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_is_passage_in = rsp_is_passage_ff;
      rsp_carved_in     = rsp_carved_ff;
      rsp_wall_row_in   = rsp_wall_row_ff;
      rsp_wall_col_in   = rsp_wall_col_ff;
      rsp_cell_row_in   = rsp_cell_row_ff;
      rsp_cell_col_in   = rsp_cell_col_ff;
      rsp_done_res_in   = rsp_done_res_ff;

      map_we = 1'b0;
      map_wa = '0;
      map_wd = 1'b0;
      map_re = 1'b0;
      map_ra = '0;
      stk_we = 1'b0;
      stk_wa = '0;
      stk_wd = '0;
      stk_re = 1'b0;
      stk_ra = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rand_in    = req_rand_value;
               passage_in = 1'b0;
               carved_in  = 1'b0;
               read_ok_in = 1'b0;
               case (req_mode)
                  mbg_pkg::MODE_START: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  mbg_pkg::MODE_STEP: begin
                     if (level_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        // Fetch the stack top
                        stk_re   = 1'b1;
                        stk_ra   = SA'(level_ff - LW'(1));
                        state_in = S_TOP;
                     end
                  end
                  mbg_pkg::MODE_READ: begin
                     map_re     = 1'b1;
                     map_ra     = {RW'(req_read_row), CW'(req_read_col)};
                     read_ok_in = live_ff && read_in_range;
                     state_in   = S_READ;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_CLEAR: begin
            // Sweep the map to walls, opening the start cell on the way
            map_we = 1'b1;
            map_wa = clr_ff;
            map_wd = (clr_ff == START_CELL);
            clr_in = clr_ff + MA'(1);
            if (&clr_ff) begin
               stk_we   = 1'b1;
               stk_wa   = '0;
               stk_wd   = START_CELL;
               level_in = LW'(1);
               live_in  = 1'b1;
               state_in = S_RESP;
            end
         end

         S_READ: begin
            passage_in = read_ok_ff && map_rd;
            state_in   = S_RESP;
         end

         S_TOP: begin
            top_in   = stk_rd;
            probe_in = '0;
            avail_in = '0;
            state_in = S_PROBE;
         end

         S_PROBE: begin
            // Issue one neighbour read per cycle, collect the previous one
            if (probe_ff != 3'd4) begin
               map_re = 1'b1;
               map_ra = nbr_addr[probe_ff[1:0]];
            end
            if (probe_ff != 3'd0) begin
               avail_in[prev_dir] = in_bounds[prev_dir] && !map_rd;
            end
            probe_in = probe_ff + 3'd1;
            if (probe_ff == 3'd4) begin
               state_in = S_PICK;
            end
         end

         S_PICK: begin
            if ((avail_ff != 4'd0) && (int'(level_ff) < STACK_DEPTH)) begin
               dir_in   = mbg_pkg::pick_dir(avail_ff, cand_pick);
               state_in = S_WALL;
            end else begin
               // Dead end or full stack: backtrack
               level_in = level_ff - LW'(1);
               state_in = S_RESP;
            end
         end

         S_WALL: begin
            map_we   = 1'b1;
            map_wa   = wall_addr[dir_ff];
            map_wd   = 1'b1;
            state_in = S_CELL;
         end

         S_CELL: begin
            map_we    = 1'b1;
            map_wa    = nbr_addr[dir_ff];
            map_wd    = 1'b1;
            stk_we    = 1'b1;
            stk_wa    = SA'(level_ff);
            stk_wd    = nbr_addr[dir_ff];
            level_in  = level_ff + LW'(1);
            carved_in = 1'b1;
            state_in  = S_RESP;
         end

         S_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_is_passage_in = passage_ff;
               rsp_carved_in     = carved_ff;
               rsp_wall_row_in   = carved_ff ? 5'(wall_addr[dir_ff][MA-1:CW]) : 5'd0;
               rsp_wall_col_in   = carved_ff ? 5'(wall_addr[dir_ff][CW-1:0]) : 5'd0;
               rsp_cell_row_in   = carved_ff ? 5'(nbr_addr[dir_ff][MA-1:CW]) : 5'd0;
               rsp_cell_col_in   = carved_ff ? 5'(nbr_addr[dir_ff][CW-1:0]) : 5'd0;
               rsp_done_res_in   = (level_ff == '0);
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      clr_ff            <= clr_in;
      rand_ff           <= rand_in;
      read_ok_ff        <= read_ok_in;
      passage_ff        <= passage_in;
      carved_ff         <= carved_in;
      top_ff            <= top_in;
      probe_ff          <= probe_in;
      avail_ff          <= avail_in;
      dir_ff            <= dir_in;
      rsp_is_passage_ff <= rsp_is_passage_in;
      rsp_carved_ff     <= rsp_carved_in;
      rsp_wall_row_ff   <= rsp_wall_row_in;
      rsp_wall_col_ff   <= rsp_wall_col_in;
      rsp_cell_row_ff   <= rsp_cell_row_in;
      rsp_cell_col_ff   <= rsp_cell_col_in;
      rsp_done_res_ff   <= rsp_done_res_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_passage = rsp_is_passage_ff;
   assign rsp_carved     = rsp_carved_ff;
   assign rsp_wall_row   = rsp_wall_row_ff;
   assign rsp_wall_col   = rsp_wall_col_ff;
   assign rsp_cell_row   = rsp_cell_row_ff;
   assign rsp_cell_col   = rsp_cell_col_ff;
   assign rsp_done_res   = rsp_done_res_ff;

   // Stack never grows past its depth
   assert property (@(posedge clock) disable iff (reset)
      int'(level_ff) <= STACK_DEPTH)
      else $error("stack level beyond depth");

   // Map is written only by the clearing sweep or once a maze exists
   assert property (@(posedge clock) disable iff (reset)
      map_we |-> (state_ff == S_CLEAR) || live_ff)
      else $error("map write before any start");

   // A carve pushes exactly one entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CELL) |=> (level_ff == $past(level_ff) + LW'(1)))
      else $error("carve did not push");

   // A carving step never reports completion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_carved_ff) |-> !rsp_done_res_ff)
      else $error("carved result flagged done");

   // An accepted item always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("transfer accepted without work");

endmodule
